@@ hw/rtl/lpm_pkg.sv @@
// Shared types, constants and helper functions of the longest prefix match router.
package lpm_pkg;

  localparam int IP_W   = 32;
  localparam int LEN_W  = 6;
  localparam int TTL_W  = 8;
  localparam int PORT_W = 2;
  localparam int STAT_W = 3;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(IP_W);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ROUTE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_ADDED   = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_TTL     = 3'd2,
    STAT_NOROUTE = 3'd3,
    STAT_FWD     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]   prefix;
    logic [LEN_W-1:0]  length;
    logic              hop_present;
    logic [IP_W-1:0]   hop;
    logic [PORT_W-1:0] port;
  } route_t;

  typedef struct packed {
    logic take_input;
    logic load_item;
    logic decide;
    logic issue;
    logic compare;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic scan_needed;
    logic all_issued;
    logic out_free;
  } dp_stat_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > LEN_MAX) ? LEN_MAX : len;
  endfunction

  // The length must already be clamped to at most 32.
  function automatic logic [IP_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [IP_W-1:0] mask;
    mask = '0;
    if (len != '0) begin
      mask = {IP_W{1'b1}} << (LEN_MAX - len);
    end
    return mask;
  endfunction

endpackage

@@ hw/rtl/lpm_in_if.sv @@
// Input channel carrying add and route words.
interface lpm_in_if
  import lpm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              command;
  logic [IP_W-1:0]   net_prefix;
  logic [LEN_W-1:0]  prefix_bits;
  logic              hop_present;
  logic [IP_W-1:0]   hop_address;
  logic [PORT_W-1:0] port_index;
  logic [IP_W-1:0]   dest_address;
  logic [TTL_W-1:0]  ttl_in;

  modport source (
    output valid, command, net_prefix, prefix_bits, hop_present, hop_address,
           port_index, dest_address, ttl_in,
    input  ready
  );

  modport sink (
    input  valid, command, net_prefix, prefix_bits, hop_present, hop_address,
           port_index, dest_address, ttl_in,
    output ready
  );
endinterface

@@ hw/rtl/lpm_out_if.sv @@
// Output channel carrying result words.
interface lpm_out_if
  import lpm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TTL_W-1:0]  ttl_out;
  logic [IP_W-1:0]   forward_address;
  logic [PORT_W-1:0] out_port;

  modport source (
    output valid, status, ttl_out, forward_address, out_port,
    input  ready
  );

  modport sink (
    input  valid, status, ttl_out, forward_address, out_port,
    output ready
  );
endinterface

@@ hw/rtl/lpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/lpm_ctrl.sv @@
// Controller state machine sequencing accept, decision, table scan and result.
module lpm_ctrl
  import lpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.in_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = stat.scan_needed ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (stat.all_issued) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.take_input = 1'b1;
        cmd.load_item  = stat.in_valid;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.issue  = stat.scan_needed;
      end
      ST_SCAN: begin
        cmd.compare = 1'b1;
        cmd.issue   = !stat.all_issued;
      end
      ST_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/lpm_datapath.sv @@
// Datapath: item register, route table, match logic, best-route tracking and result register.
module lpm_datapath
  import lpm_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 64,
  parameter int PORT_COUNT = 4
) (
  input  logic             clk,
  input  logic             rst,
  lpm_in_if.sink           request,
  lpm_out_if.source        result,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat
);

  localparam int AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CW = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ROUTE_ENTRIES);

  logic              item_command;
  logic [IP_W-1:0]   item_prefix;
  logic [LEN_W-1:0]  item_bits;
  logic              item_hop_present;
  logic [IP_W-1:0]   item_hop;
  logic [PORT_W-1:0] item_port;
  logic [IP_W-1:0]   item_dest;
  logic [TTL_W-1:0]  item_ttl;

  logic [CW-1:0]     entry_count;
  logic [CW-1:0]     rd_ptr;
  status_t           code;
  logic [LEN_W-1:0]  best_len;
  logic              best_hop_present;
  logic [IP_W-1:0]   best_hop;
  logic [PORT_W-1:0] best_port;

  logic              out_valid;
  status_t           out_status;
  logic [TTL_W-1:0]  out_ttl;
  logic [IP_W-1:0]   out_addr;
  logic [PORT_W-1:0] out_port;

  logic              table_full;
  logic              ram_we;
  route_t            wr_route;
  route_t            rd_route;
  logic              match;
  logic              take;
  logic              found;
  logic              is_fwd;

  assign request.ready = cmd.take_input;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_command     <= request.command;
      item_prefix      <= request.net_prefix;
      item_bits        <= request.prefix_bits;
      item_hop_present <= request.hop_present;
      item_hop         <= request.hop_address;
      item_port        <= request.port_index;
      item_dest        <= request.dest_address;
      item_ttl         <= request.ttl_in;
    end
  end

  assign table_full = (entry_count == FULL_COUNT);
  assign ram_we     = cmd.decide && (item_command == CMD_ADD) && !table_full;

  // The interface field has only four values, so its wrap is a constant table.
  always_comb begin
    wr_route.prefix      = item_prefix;
    wr_route.length      = clamp_len(item_bits);
    wr_route.hop_present = item_hop_present;
    wr_route.hop         = item_hop;
    case (item_port)
      2'd0:    wr_route.port = PORT_W'(0 % PORT_COUNT);
      2'd1:    wr_route.port = PORT_W'(1 % PORT_COUNT);
      2'd2:    wr_route.port = PORT_W'(2 % PORT_COUNT);
      2'd3:    wr_route.port = PORT_W'(3 % PORT_COUNT);
      default: wr_route.port = '0;
    endcase
  end

  lpm_ram #(
    .WIDTH($bits(route_t)),
    .DEPTH(ROUTE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entry_count[AW-1:0]),
    .wdata(wr_route),
    .re   (cmd.issue),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(rd_route)
  );

  assign found = (code == STAT_FWD);
  assign match = ((item_dest ^ rd_route.prefix) & len_mask(rd_route.length)) == '0;
  assign take  = match && (!found || (best_len < rd_route.length));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ram_we) begin
      entry_count <= entry_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rd_ptr <= '0;
    end else if (cmd.issue) begin
      rd_ptr <= rd_ptr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (item_command == CMD_ADD) begin
        code <= table_full ? STAT_FULL : STAT_ADDED;
      end else if (item_ttl <= TTL_W'(1)) begin
        code <= STAT_TTL;
      end else begin
        code <= STAT_NOROUTE;
      end
    end else if (cmd.compare && take) begin
      code             <= STAT_FWD;
      best_len         <= rd_route.length;
      best_hop_present <= rd_route.hop_present;
      best_hop         <= rd_route.hop;
      best_port        <= rd_route.port;
    end
  end

  assign stat.in_valid    = request.valid;
  assign stat.scan_needed = (item_command == CMD_ROUTE) && (item_ttl > TTL_W'(1))
                            && (entry_count != '0);
  assign stat.all_issued  = (rd_ptr == entry_count);
  assign stat.out_free    = !out_valid || result.ready;

  assign is_fwd = (code == STAT_FWD);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= code;
      out_ttl    <= is_fwd ? item_ttl - TTL_W'(1) : '0;
      out_addr   <= is_fwd ? (best_hop_present ? best_hop : item_dest) : '0;
      out_port   <= is_fwd ? best_port : '0;
    end
  end

  assign result.valid           = out_valid;
  assign result.status          = out_status;
  assign result.ttl_out         = out_ttl;
  assign result.forward_address = out_addr;
  assign result.out_port        = out_port;

endmodule

@@ hw/rtl/longest_prefix_match_router.sv @@
// Top level of the IPv4 longest prefix match router.
// An add word goes from acceptance through the decide and finish states to the result register.
// A route word with TTL above 1 and a nonempty table also scans the table before the finish state,
// where the scan reads one stored route per cycle from the single read port of the route memory;
// a new word is accepted only once the result of the last word has been loaded.
// Reset empties the table by clearing the route count and the control state; memory is untouched.
module longest_prefix_match_router
  import lpm_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 64,
  parameter int PORT_COUNT = 4
) (
  input logic        clk,
  input logic        rst,
  lpm_in_if.sink     request,
  lpm_out_if.source  result
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  lpm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .cmd (cmd)
  );

  lpm_datapath #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .PORT_COUNT   (PORT_COUNT)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .request(request),
    .result (result),
    .cmd    (cmd),
    .stat   (stat)
  );

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register loaded while a word is still pending");

  // The scan never reads past the stored routes.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && !cmd.decide) |-> !stat.all_issued)
    else $error("route memory read beyond the route count");

  // After a word is accepted the block is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("input accepted again right after a word was taken");

endmodule

@@ dv/tb_longest_prefix_match_router.sv @@
`timescale 1ns / 1ps
// Testbench that checks the longest prefix match router against a self-contained route table model.
module tb_longest_prefix_match_router;
  import lpm_pkg::*;

  localparam int ROUTE_ENTRIES = 64;
  localparam int PORT_COUNT = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ADD_CAP = 60;

  typedef struct {
    logic              command;
    logic [IP_W-1:0]   net_prefix;
    logic [LEN_W-1:0]  prefix_bits;
    logic              hop_present;
    logic [IP_W-1:0]   hop_address;
    logic [PORT_W-1:0] port_index;
    logic [IP_W-1:0]   dest_address;
    logic [TTL_W-1:0]  ttl_in;
  } request_word_t;

  typedef struct {
    status_t           status;
    logic [TTL_W-1:0]  ttl_out;
    logic [IP_W-1:0]   forward_address;
    logic [PORT_W-1:0] out_port;
  } verdict_t;

  logic clk;
  logic rst;

  lpm_in_if  req ();
  lpm_out_if rsp ();

  longest_prefix_match_router #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .PORT_COUNT(PORT_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .request(req),
    .result(rsp)
  );

  route_t      route_table [ROUTE_ENTRIES];
  int unsigned route_count;
  verdict_t    pending_verdicts [$];
  int          error_count;
  int          result_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_request;
  int          hold_left;

  always #6 clk = ~clk;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.command = CMD_ADD;
    req.net_prefix = '0;
    req.prefix_bits = '0;
    req.hop_present = 1'b0;
    req.hop_address = '0;
    req.port_index = '0;
    req.dest_address = '0;
    req.ttl_in = '0;
    rsp.ready = 1'b0;
    route_count = 0;
    error_count = 0;
    result_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
  end

  function automatic logic [LEN_W-1:0] effective_length(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(IP_W)) ? LEN_W'(IP_W) : len;
  endfunction

  function automatic logic [IP_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] eff;
    eff = effective_length(len);
    if (eff == '0) return '0;
    return 32'hFFFF_FFFF << (IP_W - int'(eff));
  endfunction

  function automatic verdict_t predict_forwarding(input request_word_t w);
    verdict_t         v;
    logic             found;
    int               best;
    logic [LEN_W-1:0] best_len;
    logic [LEN_W-1:0] eff;
    logic [IP_W-1:0]  mask;
    v.status = STAT_ADDED;
    v.ttl_out = '0;
    v.forward_address = '0;
    v.out_port = '0;
    found = 1'b0;
    best = 0;
    best_len = '0;
    if (w.command == CMD_ADD) begin
      if (route_count >= ROUTE_ENTRIES) begin
        v.status = STAT_FULL;
      end else begin
        route_table[route_count].prefix = w.net_prefix;
        route_table[route_count].length = w.prefix_bits;
        route_table[route_count].hop_present = w.hop_present;
        route_table[route_count].hop = w.hop_address;
        route_table[route_count].port = PORT_W'(int'(w.port_index) % PORT_COUNT);
        route_count++;
      end
    end else if (w.ttl_in <= TTL_W'(1)) begin
      v.status = STAT_TTL;
    end else begin
      for (int i = 0; i < int'(route_count); i++) begin
        eff = effective_length(route_table[i].length);
        mask = prefix_mask(route_table[i].length);
        if ((w.dest_address & mask) == (route_table[i].prefix & mask) &&
            (!found || eff > best_len)) begin
          found = 1'b1;
          best = i;
          best_len = eff;
        end
      end
      if (!found) begin
        v.status = STAT_NOROUTE;
      end else begin
        v.status = STAT_FWD;
        v.ttl_out = w.ttl_in - TTL_W'(1);
        v.forward_address = route_table[best].hop_present ? route_table[best].hop
                                                           : w.dest_address;
        v.out_port = route_table[best].port;
      end
    end
    return v;
  endfunction

  function automatic request_word_t random_word();
    request_word_t w;
    w.command = 1'($urandom_range(1));
    w.net_prefix = $urandom;
    w.prefix_bits = LEN_W'($urandom_range(63));
    w.hop_present = 1'($urandom_range(1));
    w.hop_address = $urandom;
    w.port_index = PORT_W'($urandom_range(3));
    w.dest_address = $urandom;
    w.ttl_in = TTL_W'($urandom_range(255));
    return w;
  endfunction

  function automatic request_word_t add_word(input logic [IP_W-1:0] prefix,
                                             input logic [LEN_W-1:0] len,
                                             input logic has_hop,
                                             input logic [IP_W-1:0] hop,
                                             input logic [PORT_W-1:0] port);
    request_word_t w;
    w = random_word();
    w.command = CMD_ADD;
    w.net_prefix = prefix;
    w.prefix_bits = len;
    w.hop_present = has_hop;
    w.hop_address = hop;
    w.port_index = port;
    return w;
  endfunction

  function automatic request_word_t datagram_word(input logic [IP_W-1:0] dest,
                                                  input logic [TTL_W-1:0] ttl);
    request_word_t w;
    w = random_word();
    w.command = CMD_ROUTE;
    w.dest_address = dest;
    w.ttl_in = ttl;
    return w;
  endfunction

  function automatic request_word_t random_add(input bit allow_default);
    request_word_t w;
    int            pick;
    w = random_word();
    w.command = CMD_ADD;
    if ($urandom_range(9) == 0) begin
      w.prefix_bits = LEN_W'($urandom_range(63, 33));
    end else begin
      w.prefix_bits = LEN_W'($urandom_range(32, allow_default ? 0 : 1));
    end
    if (route_count != 0 && $urandom_range(99) < 40) begin
      pick = $urandom_range(route_count - 1);
      w.net_prefix = route_table[pick].prefix;
    end
    return w;
  endfunction

  function automatic request_word_t random_datagram();
    request_word_t   w;
    int              pick;
    logic [IP_W-1:0] mask;
    w = random_word();
    w.command = CMD_ROUTE;
    if ($urandom_range(9) == 0) begin
      w.ttl_in = TTL_W'($urandom_range(1));
    end else begin
      w.ttl_in = TTL_W'($urandom_range(255, 2));
    end
    if (route_count != 0 && $urandom_range(99) < 70) begin
      pick = $urandom_range(route_count - 1);
      mask = prefix_mask(route_table[pick].length);
      w.dest_address = (route_table[pick].prefix & mask) | (w.dest_address & ~mask);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint wanted);
    $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h", result_count, what, got, wanted);
    error_count++;
  endtask

  // The valid stays high after acceptance so that back-to-back words need no extra step.
  task automatic send_word(input request_word_t w);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid <= 1'b1;
    req.command <= w.command;
    req.net_prefix <= w.net_prefix;
    req.prefix_bits <= w.prefix_bits;
    req.hop_present <= w.hop_present;
    req.hop_address <= w.hop_address;
    req.port_index <= w.port_index;
    req.dest_address <= w.dest_address;
    req.ttl_in <= w.ttl_in;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    pending_verdicts.insert(pending_verdicts.size(), predict_forwarding(w));
  endtask

  task automatic pause_until_drained();
    req.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result word with nothing pending, status", rsp.status, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.ttl_out !== want.ttl_out)
          report_mismatch("ttl_out", rsp.ttl_out, want.ttl_out);
        if (rsp.forward_address !== want.forward_address)
          report_mismatch("forward_address", rsp.forward_address, want.forward_address);
        if (rsp.out_port !== want.out_port)
          report_mismatch("out_port", rsp.out_port, want.out_port);
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** longest_prefix_match_router: FAILED **");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_word(datagram_word(32'h0000_0000, 8'd255));
    send_word(datagram_word(32'hFFFF_FFFF, 8'd0));
    send_word(datagram_word(32'h0A01_0203, 8'd1));
    send_word(datagram_word(32'h0A01_0203, 8'd2));
  endtask

  task automatic test_directed_routes();
    send_word(add_word(32'h0A00_0000, 6'd8, 1'b0, $urandom, 2'd1));
    send_word(add_word(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 2'd2));
    send_word(add_word(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0002, 2'd3));
    send_word(add_word(32'h0A01_0203, 6'd63, 1'b1, 32'hAC10_0009, 2'd0));
    send_word(add_word(32'hC0A8_014D, 6'd24, 1'b0, 32'hFFFF_FFFF, 2'd3));
    send_word(add_word(32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 2'd2));
    send_word(add_word(32'h0000_0000, 6'd1, 1'b1, 32'hFFFF_FFFF, 2'd0));
    send_word(datagram_word(32'h0A01_0203, 8'd2));
    send_word(datagram_word(32'h0A01_C807, 8'd64));
    send_word(datagram_word(32'h0A4D_0001, 8'd255));
    send_word(datagram_word(32'hC0A8_0105, 8'd3));
    send_word(datagram_word(32'hFFFF_FFFF, 8'd255));
    send_word(datagram_word(32'h0000_0000, 8'd128));
    send_word(datagram_word(32'h8000_0001, 8'd100));
    send_word(datagram_word(32'h0A01_0203, 8'd1));
    send_word(datagram_word(32'h0A01_0203, 8'd0));
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      if (route_count < RANDOM_ADD_CAP && $urandom_range(99) < 8) begin
        send_word(random_add(1'b0));
      end else begin
        send_word(random_datagram());
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 300;
    repeat (16) send_word(random_datagram());
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_stall_pct = 37;
    repeat (8) send_word(random_datagram());
    pause_until_drained();
    repeat (8) send_word(random_datagram());
  endtask

  task automatic test_full_table();
    send_idle_pct = 37;
    recv_stall_pct = 37;
    send_word(add_word(32'h0000_0000, 6'd0, 1'b1, 32'h0A00_00FE, 2'd3));
    repeat (6) send_word(random_datagram());
    while (route_count < ROUTE_ENTRIES) begin
      send_word(random_add(1'b1));
      send_word(random_datagram());
    end
    repeat (4) send_word(random_add(1'b1));
    repeat (12) send_word(random_datagram());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_directed_routes();
    test_random_traffic(300, 0, 0);
    test_backpressure();
    test_random_traffic(300, 76, 0);
    test_drain_pause();
    test_random_traffic(300, 0, 76);
    test_random_traffic(300, 37, 37);
    test_full_table();
    pause_until_drained();
    repeat (ROUTE_ENTRIES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("** longest_prefix_match_router: PASSED **");
    end else begin
      $display("** longest_prefix_match_router: FAILED **");
    end
    $finish;
  end

endmodule
